FILE: design/ryc_pkg.sv
// shared types and constants for the rgb/yuv channel shifter
package ryc_pkg;

  localparam int CHAN_W = 8;
  localparam int FRAC_W = 17;
  localparam int CHAN_MAX = 255;

  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;
  localparam logic [1:0] MODE_YUV  = 2'd2;
  localparam logic [1:0] MODE_TGT  = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_RED    = 3'd1;
  localparam logic [2:0] REG_GREEN  = 3'd2;
  localparam logic [2:0] REG_BLUE   = 3'd3;
  localparam logic [2:0] REG_LUMA   = 3'd4;
  localparam logic [2:0] REG_CB     = 3'd5;
  localparam logic [2:0] REG_CR     = 3'd6;
  localparam logic [2:0] REG_TARGET = 3'd7;

  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [14:0] SHIFT_MAX = 15'd16384;

  // forward coefficients, magnitudes
  localparam logic [16:0] KY_R = 17'd19595;
  localparam logic [16:0] KY_G = 17'd38470;
  localparam logic [16:0] KY_B = 17'd7471;
  localparam logic [16:0] KU_R = 17'd11058;
  localparam logic [16:0] KU_G = 17'd21710;
  localparam logic [16:0] KU_B = 17'd32768;
  localparam logic [16:0] KV_R = 17'd32768;
  localparam logic [16:0] KV_G = 17'd27439;
  localparam logic [16:0] KV_B = 17'd5329;

  // inverse coefficients
  localparam logic signed [17:0] KR_V = 18'sd91881;
  localparam logic signed [17:0] KG_U = 18'sd22553;
  localparam logic signed [17:0] KG_V = 18'sd46802;
  localparam logic signed [17:0] KB_U = 18'sd116130;

  typedef logic [FRAC_W-1:0] frac_t;

  typedef struct packed {
    frac_t c0;
    frac_t c1;
    frac_t c2;
  } trip_t;

  typedef struct packed {
    logic              pass;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } side_t;

endpackage

FILE: design/ryc_pix_if.sv
// rgba pixel stream channel with valid/ready handshake
interface ryc_pix_if
  import ryc_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, output red, output green, output blue, output alpha,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

FILE: design/rgb_yuv_channel_shift.sv
// rgba colour shifter: rgb shift, yuv shift and target chroma over an 8-stage pipeline
//
//  channel   dir  handshake       payload
//  in_pix    in   valid/ready     red green blue alpha, 8 bits each
//  out_pix   out  valid/ready     red green blue alpha, 8 bits each
//  cfg_*     in   cfg_we strobe   cfg_index 3 bits, cfg_data 24 bits
//
// one beat per cycle in, one per cycle out while out_pix does not stall; each beat
// passes through one pipeline register per stage (fraction, forward products, yuv,
// shift products, shift, inverse products, rgb, output byte).
// synchronous active-low reset empties the pipeline and clears the config registers.
// a stall on out_pix holds a full stage only when every later stage is full; empty stages keep filling.
module rgb_yuv_channel_shift
  import ryc_pkg::*;
  (
  input  logic                clk,
  input  logic                rst_n,
  ryc_pix_if.sink             in_pix,
  ryc_pix_if.source           out_pix,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [23:0]         cfg_data
);

  localparam int NSTG = 8;

  function automatic frac_t to_frac(input logic [CHAN_W-1:0] c);
    return {1'b0, c, 8'b0} + FRAC_W'(c) + FRAC_W'(c[CHAN_W-1]);
  endfunction

  function automatic logic [31:0] umul(input frac_t a, input logic [16:0] k);
    logic [33:0] p;
    p = {17'b0, a} * {17'b0, k};
    return p[31:0];
  endfunction

  function automatic logic signed [35:0] smul(input logic signed [17:0] a,
                                              input logic signed [17:0] k);
    return a * k;
  endfunction

  function automatic frac_t rnd_clamp(input logic signed [35:0] x);
    logic signed [35:0] t;
    frac_t              res;
    t = x + 36'sd32768;
    if (x < 0) begin
      res = '0;
    end else if (t[35:16] > {3'b0, ONE_Q16}) begin
      res = ONE_Q16;
    end else begin
      res = t[32:16];
    end
    return res;
  endfunction

  // config registers
  logic [1:0]         mode_r;
  logic signed [15:0] shift_r [6];
  logic [23:0]        target_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PASS;
      target_r <= '0;
      for (int i = 0; i < 6; i++) shift_r[i] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:   mode_r     <= cfg_data[1:0];
        REG_RED:    shift_r[0] <= cfg_data[15:0];
        REG_GREEN:  shift_r[1] <= cfg_data[15:0];
        REG_BLUE:   shift_r[2] <= cfg_data[15:0];
        REG_LUMA:   shift_r[3] <= cfg_data[15:0];
        REG_CB:     shift_r[4] <= cfg_data[15:0];
        REG_CR:     shift_r[5] <= cfg_data[15:0];
        REG_TARGET: target_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic is_yuv;
  assign is_yuv = mode_r inside {MODE_YUV, MODE_TGT};

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;
  side_t           side_r [NSTG];
  side_t           side_nxt;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_pix.ready;
    for (int k = NSTG - 2; k >= 0; k--) en[k] = !vld_r[k] || en[k+1];
  end

  assign vld_nxt = {vld_r[NSTG-2:0], in_pix.valid};
  assign in_pix.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) if (en[k]) vld_r[k] <= vld_nxt[k];
    end
  end

  always_comb begin
    side_nxt.pass  = (mode_r == MODE_RGB && shift_r[0] == 0 && shift_r[1] == 0 &&
                      shift_r[2] == 0) ||
                     (mode_r == MODE_YUV && shift_r[3] == 0 && shift_r[4] == 0 &&
                      shift_r[5] == 0);
    side_nxt.red   = in_pix.red;
    side_nxt.green = in_pix.green;
    side_nxt.blue  = in_pix.blue;
    side_nxt.alpha = in_pix.alpha;
  end

  always_ff @(posedge clk) begin
    if (en[0]) side_r[0] <= side_nxt;
    for (int k = 1; k < NSTG; k++) if (en[k]) side_r[k] <= side_r[k-1];
  end

  // stage 1: fractions
  trip_t pix1_r, src1_r, pix1_nxt, tgt1;

  always_comb begin
    pix1_nxt.c0 = to_frac(in_pix.red);
    pix1_nxt.c1 = to_frac(in_pix.green);
    pix1_nxt.c2 = to_frac(in_pix.blue);
    tgt1.c0     = to_frac(target_r[23:16]);
    tgt1.c1     = to_frac(target_r[15:8]);
    tgt1.c2     = to_frac(target_r[7:0]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix1_r <= pix1_nxt;
      src1_r <= (mode_r == MODE_TGT) ? tgt1 : pix1_nxt;
    end
  end

  // stage 2: forward products
  logic [31:0] fp2_r [9];
  trip_t       pix2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fp2_r[0] <= umul(pix1_r.c0, KY_R);
      fp2_r[1] <= umul(pix1_r.c1, KY_G);
      fp2_r[2] <= umul(pix1_r.c2, KY_B);
      fp2_r[3] <= umul(src1_r.c0, KU_R);
      fp2_r[4] <= umul(src1_r.c1, KU_G);
      fp2_r[5] <= umul(src1_r.c2, KU_B);
      fp2_r[6] <= umul(src1_r.c0, KV_R);
      fp2_r[7] <= umul(src1_r.c1, KV_G);
      fp2_r[8] <= umul(src1_r.c2, KV_B);
      pix2_r   <= pix1_r;
    end
  end

  // stage 3: yuv sums and shift selection
  localparam logic signed [35:0] UV_OFFSET = 36'sd2147483648;

  trip_t              w3_r, w3_nxt;
  logic [14:0]        mag3_r [3];
  logic [2:0]         pos3_r;
  logic signed [35:0] ysum, usum, vsum;
  logic signed [15:0] ssel [3];
  logic [14:0]        mag_nxt [3];
  logic [2:0]         pos_nxt;

  always_comb begin
    ysum = $signed({4'b0, fp2_r[0]}) + $signed({4'b0, fp2_r[1]}) +
           $signed({4'b0, fp2_r[2]});
    usum = UV_OFFSET - $signed({4'b0, fp2_r[3]}) - $signed({4'b0, fp2_r[4]}) +
           $signed({4'b0, fp2_r[5]});
    vsum = UV_OFFSET + $signed({4'b0, fp2_r[6]}) - $signed({4'b0, fp2_r[7]}) -
           $signed({4'b0, fp2_r[8]});
    if (is_yuv) begin
      w3_nxt.c0 = rnd_clamp(ysum);
      w3_nxt.c1 = rnd_clamp(usum);
      w3_nxt.c2 = rnd_clamp(vsum);
    end else begin
      w3_nxt = pix2_r;
    end
    for (int i = 0; i < 3; i++) begin
      case (mode_r)
        MODE_RGB: ssel[i] = shift_r[i];
        MODE_YUV: ssel[i] = shift_r[i+3];
        default:  ssel[i] = '0;
      endcase
      pos_nxt[i] = (ssel[i] > 0);
      if (ssel[i] > $signed({1'b0, SHIFT_MAX}) ||
          ssel[i] < -$signed({1'b0, SHIFT_MAX})) begin
        mag_nxt[i] = SHIFT_MAX;
      end else if (ssel[i] < 0) begin
        mag_nxt[i] = 15'(-ssel[i]);
      end else begin
        mag_nxt[i] = ssel[i][14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      w3_r   <= w3_nxt;
      pos3_r <= pos_nxt;
      for (int i = 0; i < 3; i++) mag3_r[i] <= mag_nxt[i];
    end
  end

  // stage 4: shift products
  logic [30:0] sp4_r [3];
  trip_t       w4_r;
  logic [2:0]  pos4_r;
  frac_t       w3_c [3];
  frac_t       span [3];
  logic [31:0] sprod [3];

  assign w3_c[0] = w3_r.c0;
  assign w3_c[1] = w3_r.c1;
  assign w3_c[2] = w3_r.c2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      span[i]  = pos3_r[i] ? (ONE_Q16 - w3_c[i]) : w3_c[i];
      sprod[i] = {15'b0, span[i]} * {17'b0, mag3_r[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 3; i++) sp4_r[i] <= sprod[i][30:0];
      w4_r   <= w3_r;
      pos4_r <= pos3_r;
    end
  end

  // stage 5: apply shift
  trip_t       s5_r;
  frac_t       w4_c [3];
  frac_t       sh_c [3];
  logic [31:0] rnd_sp [3];

  assign w4_c[0] = w4_r.c0;
  assign w4_c[1] = w4_r.c1;
  assign w4_c[2] = w4_r.c2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd_sp[i] = {1'b0, sp4_r[i]} + 32'd8192;
      sh_c[i]   = pos4_r[i] ? (w4_c[i] + rnd_sp[i][30:14]) : (w4_c[i] - rnd_sp[i][30:14]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) s5_r <= '{c0: sh_c[0], c1: sh_c[1], c2: sh_c[2]};
  end

  // stage 6: inverse products
  logic signed [35:0] ip6_r [4];
  trip_t              s6_r;
  logic signed [17:0] u2, v2;

  assign u2 = $signed({1'b0, s5_r.c1}) - $signed({1'b0, HALF_Q16});
  assign v2 = $signed({1'b0, s5_r.c2}) - $signed({1'b0, HALF_Q16});

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ip6_r[0] <= smul(v2, KR_V);
      ip6_r[1] <= smul(u2, KG_U);
      ip6_r[2] <= smul(v2, KG_V);
      ip6_r[3] <= smul(u2, KB_U);
      s6_r     <= s5_r;
    end
  end

  // stage 7: rgb sums
  trip_t              f7_r, f7_nxt;
  logic signed [35:0] yy;

  always_comb begin
    yy = $signed({3'b0, s6_r.c0, 16'b0});
    if (is_yuv) begin
      f7_nxt.c0 = rnd_clamp(yy + ip6_r[0]);
      f7_nxt.c1 = rnd_clamp(yy - ip6_r[1] - ip6_r[2]);
      f7_nxt.c2 = rnd_clamp(yy + ip6_r[3]);
    end else begin
      f7_nxt = s6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) f7_r <= f7_nxt;
  end

  // stage 8: back to bytes and final selection
  logic [CHAN_W-1:0] ob_r [3];
  logic [CHAN_W-1:0] oa_r;
  frac_t             f7_c [3];
  logic [23:0]       chq [3];
  logic [CHAN_W-1:0] ob_nxt [3];
  logic [CHAN_W-1:0] raw7 [3];

  assign f7_c[0] = f7_r.c0;
  assign f7_c[1] = f7_r.c1;
  assign f7_c[2] = f7_r.c2;
  assign raw7[0] = side_r[6].red;
  assign raw7[1] = side_r[6].green;
  assign raw7[2] = side_r[6].blue;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      chq[i] = 24'(f7_c[i]) * 24'(CHAN_MAX) + 24'(HALF_Q16);
      if (side_r[6].pass) begin
        ob_nxt[i] = raw7[i];
      end else if (side_r[6].alpha == '0) begin
        ob_nxt[i] = '0;
      end else begin
        ob_nxt[i] = chq[i][23:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int i = 0; i < 3; i++) ob_r[i] <= ob_nxt[i];
      oa_r <= side_r[6].alpha;
    end
  end

  assign out_pix.valid = vld_r[NSTG-1];
  assign out_pix.red   = ob_r[0];
  assign out_pix.green = ob_r[1];
  assign out_pix.blue  = ob_r[2];
  assign out_pix.alpha = oa_r;

`ifndef SYNTH
  // an accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_pix.valid && in_pix.ready) |=> vld_r[0])
    else $error("accepted beat did not enter stage one");

  // pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

  // zero alpha without bypass gives a black pixel
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && !side_r[NSTG-1].pass && out_pix.alpha == '0) |->
    (out_pix.red == '0 && out_pix.green == '0 && out_pix.blue == '0))
    else $error("zero alpha pixel not cleared");

  // bypassed beats come out as they went in
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && side_r[NSTG-1].pass) |->
    (out_pix.red == side_r[NSTG-1].red && out_pix.green == side_r[NSTG-1].green &&
     out_pix.blue == side_r[NSTG-1].blue))
    else $error("bypassed pixel altered");
`endif

endmodule
